// ===== rtl/core/rmdpc_pkg.sv =====
package rmdpc_pkg;

  localparam int ROM_BYTES_DEF = 5000;

  // Program pointer width and the reset address
  localparam int             PTR_W     = 15;
  localparam logic [PTR_W-1:0] PTR_RESET = 15'd222;
  // Upper bound: digit 15 shifted in on top of the largest quotient
  localparam logic [PTR_W-1:0] PTR_MAX   = 15'd18276;
  localparam logic [PTR_W-1:0] DIGIT_WEIGHT = 15'd1000;

  localparam logic [3:0] SUB_ACT = 4'd15;

  // Instruction words recognised on the bus
  localparam logic [15:0] INSTR_DATA   = 16'h0A0E;
  localparam logic [15:0] INSTR_SHIFT  = 16'h0A1E;
  localparam logic [15:0] INSTR_UNLOAD = 16'h0A2E;
  localparam logic [15:0] INSTR_HIGH   = 16'h0A3E;

  localparam logic ACTION_BUS  = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_NONE   = 3'd0;
  localparam cmd_t CMD_DATA   = 3'd1;
  localparam cmd_t CMD_UNLOAD = 3'd2;
  localparam cmd_t CMD_HIGH   = 3'd4;

  localparam int CMD_DATA_BIT   = 0;
  localparam int CMD_UNLOAD_BIT = 1;
  localparam int CMD_HIGH_BIT   = 2;

  typedef struct packed {
    logic        action;
    logic [3:0]  sub_state;
    logic        is_write_phase;
    logic [15:0] instr_word;
    logic [3:0]  ext_digit;
    logic [12:0] load_addr;
    logic [7:0]  load_byte;
  } req_t;

  typedef struct packed {
    logic       drive;
    logic [7:0] drive_value;
  } res_t;

  // Quotient by ten via reciprocal 52429 / 2^19, exact over the pointer range
  function automatic logic [PTR_W-1:0] div10(input logic [PTR_W-1:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd52429;
    return PTR_W'(prod[31:19]);
  endfunction

endpackage

// ===== rtl/core/rmdpc_if.sv =====
interface rmdpc_req_if;
  import rmdpc_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmdpc_res_if;
  import rmdpc_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rom_module_decimal_pc_bus_device.sv =====
// Plug-in program ROM with a decimal program pointer, seen from the chip bus.
//
// req channel: one request per bus access or ROM load (valid/ready, taken on
// a clock edge with both high). Loads write one ROM byte; bus accesses act
// only in sub-cycle 15, decoding instruction words in the instruction phase
// and driving the active command's value in the output phase.
// res channel: exactly one result per request, drive flag and 8-bit value.
//
// The result is registered and offered in the cycle after its request is taken.
// Throughput: one request per cycle unless the receiver stalls. The pointer
// update does not depend on ROM data, so it completes in the accept cycle;
// the ROM read issued there returns through the memory's registered read port.
//
// Reset (rst, synchronous): pointer to 222, both command slots cleared, no
// result held. ROM contents are not cleared; the user must load every byte
// before use, which the block does not enforce. Receiver stall: the held
// result and the ROM read data stay put; req ready drops until it is taken.
module rom_module_decimal_pc_bus_device #(
  parameter int ROM_BYTES = rmdpc_pkg::ROM_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  rmdpc_req_if.sink   req,
  rmdpc_res_if.source res
);
  import rmdpc_pkg::*;

  localparam int                ADDR_W    = $clog2(ROM_BYTES);
  localparam logic [PTR_W:0]    PTR_LIMIT = (PTR_W+1)'(ROM_BYTES);
  localparam logic [13:0]       LOAD_LIMIT = 14'(ROM_BYTES);

  // What the held result shows
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_ROM,
    SRC_HIGH,
    SRC_DIGIT
  } src_t;

  logic [PTR_W-1:0] ptr, ptr_next;
  cmd_t             pending_cmd, pending_cmd_next;
  cmd_t             active_cmd, active_cmd_next;

  logic             res_valid;
  src_t             res_src, res_src_next;
  logic             res_oob, res_oob_next;
  logic [3:0]       res_digit;

  logic             accept;
  logic             bus_act;
  logic             in_rom;
  logic [PTR_W-1:0] ptr_q;
  logic [3:0]       ptr_r;
  logic [PTR_W:0]   ptr_inc;
  logic             rom_rd_en;
  logic             rom_wr_en;
  logic [7:0]       rom_rd_data;

  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign bus_act   = accept && (req.data.action == ACTION_BUS) &&
                     (req.data.sub_state == SUB_ACT);

  assign in_rom  = {1'b0, ptr} < PTR_LIMIT;
  assign ptr_q   = div10(ptr);
  assign ptr_r   = 4'(ptr - PTR_W'(ptr_q * PTR_W'(10)));
  assign ptr_inc = {1'b0, ptr} + 1'b1;

  assign rom_wr_en = accept && (req.data.action == ACTION_LOAD) &&
                     ({1'b0, req.data.load_addr} < LOAD_LIMIT);

  always_comb begin
    ptr_next         = ptr;
    pending_cmd_next = pending_cmd;
    active_cmd_next  = active_cmd;
    res_src_next     = SRC_NONE;
    res_oob_next     = !in_rom;
    rom_rd_en        = 1'b0;
    if (bus_act) begin
      if (req.data.is_write_phase) begin
        // output phase: first active bit wins
        if (active_cmd[CMD_DATA_BIT]) begin
          res_src_next = SRC_ROM;
          rom_rd_en    = in_rom;
          ptr_next     = (ptr_inc >= PTR_LIMIT) ? '0 : ptr_inc[PTR_W-1:0];
        end else if (active_cmd[CMD_UNLOAD_BIT]) begin
          res_src_next = SRC_DIGIT;
          ptr_next     = ptr_q;
        end else if (active_cmd[CMD_HIGH_BIT]) begin
          res_src_next = SRC_HIGH;
          rom_rd_en    = in_rom;
        end
      end else begin
        active_cmd_next = pending_cmd;
        case (req.data.instr_word)
          INSTR_DATA:   pending_cmd_next = CMD_DATA;
          INSTR_UNLOAD: pending_cmd_next = CMD_UNLOAD;
          INSTR_HIGH:   pending_cmd_next = CMD_HIGH;
          INSTR_SHIFT: begin
            pending_cmd_next = CMD_NONE;
            ptr_next = ptr_q + PTR_W'(PTR_W'(req.data.ext_digit) * DIGIT_WEIGHT);
          end
          default:      pending_cmd_next = CMD_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr         <= PTR_RESET;
      pending_cmd <= CMD_NONE;
      active_cmd  <= CMD_NONE;
      res_valid   <= 1'b0;
      res_src     <= SRC_NONE;
    end else begin
      ptr         <= ptr_next;
      pending_cmd <= pending_cmd_next;
      active_cmd  <= active_cmd_next;
      if (accept) begin
        res_valid <= 1'b1;
        res_src   <= res_src_next;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_oob   <= res_oob_next;
      res_digit <= ptr_r;
    end
  end

  rmdpc_rom #(
    .ROM_BYTES (ROM_BYTES),
    .ADDR_W    (ADDR_W)
  ) u_rom (
    .clk     (clk),
    .wr_en   (rom_wr_en),
    .wr_addr (req.data.load_addr[ADDR_W-1:0]),
    .wr_data (req.data.load_byte),
    .rd_en   (rom_rd_en),
    .rd_addr (ptr[ADDR_W-1:0]),
    .rd_data (rom_rd_data)
  );

  assign res.valid = res_valid;

  always_comb begin
    res.data.drive       = 1'b0;
    res.data.drive_value = '0;
    case (res_src)
      SRC_ROM: begin
        res.data.drive       = 1'b1;
        res.data.drive_value = res_oob ? 8'd0 : rom_rd_data;
      end
      SRC_HIGH: begin
        res.data.drive       = 1'b1;
        res.data.drive_value = res_oob ? 8'd0 : {4'd0, rom_rd_data[7:4]};
      end
      SRC_DIGIT: begin
        res.data.drive       = 1'b1;
        res.data.drive_value = {4'd0, res_digit};
      end
      default: begin
        res.data.drive       = 1'b0;
        res.data.drive_value = '0;
      end
    endcase
  end

  // only one command bit is ever armed
  a_pending_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pending_cmd))
    else $error("pending command has more than one bit set");

  a_active_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(active_cmd))
    else $error("active command has more than one bit set");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_MAX)
    else $error("pointer beyond its reachable range");

  // ROM data behind a held result must not move while the receiver stalls
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |=> $stable(rom_rd_data))
    else $error("ROM read data changed under a stalled result");

  a_no_read_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |-> !rom_rd_en && !rom_wr_en)
    else $error("ROM accessed while the result is stalled");

endmodule

// ===== rtl/core/rmdpc_rom.sv =====
module rmdpc_rom #(
  parameter int ROM_BYTES = rmdpc_pkg::ROM_BYTES_DEF,
  parameter int ADDR_W    = $clog2(ROM_BYTES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [ROM_BYTES];

  // Single write port, single read port, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== test/testbench.sv =====
// Testbench for the plug-in program ROM on the calculator chip bus.
//
// The sender issues one request at a time on the req channel. At acceptance,
// a local copy of the block (program pointer, ROM image, both command slots)
// works out the single result that the request must produce. That result is
// queued. A monitor on the res channel checks each result against the
// oldest queued one, field by field.
//
// The ROM contents are undefined until written. A ROM read of an address
// that has never been loaded is therefore kept out: before an output phase
// that reads rom[pointer] at an unloaded address, a load of that address is
// slipped in. Explicit loads go to any 13-bit address, the ignored ones
// above the ROM included.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rmdpc_pkg::*;

  localparam int ROM_SIZE   = ROM_BYTES_DEF;
  localparam int WAIT_LIMIT = 200000; // cycles; slowest legal run is far below
  localparam int RAND_REQS  = 1200;

  // Opcode that matches none of the four recognised instruction words
  localparam logic [15:0] INSTR_NOP = 16'h0000;

  logic clk;
  logic rst;

  rmdpc_req_if req_ch ();
  rmdpc_res_if res_ch ();

  rom_module_decimal_pc_bus_device dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the block's state
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0] pc_model;
  logic [7:0]       rom_image  [ROM_SIZE];
  bit               rom_loaded [ROM_SIZE];
  cmd_t             pending_op;
  cmd_t             active_op;

  res_t resp_due [$];   // results owed by the block, oldest first
  bit   gaps_on;        // random idling on both channels
  bit   mismatch_seen;
  int   cycle_count;

  function automatic logic [7:0] rom_byte(input int addr);
    if (addr >= ROM_SIZE) return 8'd0;   // beyond the ROM reads as zero
    return rom_image[addr];
  endfunction

  // Does the active command read rom[pointer] in an output phase?
  // Priority is data read, then unload, then high nibble.
  function automatic bit reads_rom();
    return active_op[CMD_DATA_BIT] ||
           (!active_op[CMD_UNLOAD_BIT] && active_op[CMD_HIGH_BIT]);
  endfunction

  // Applies one accepted request to the local state; returns its result.
  function automatic res_t bus_response(input req_t r);
    res_t o;
    int   p;
    o = '0;
    p = pc_model;
    if (r.action == ACTION_LOAD) begin
      // out-of-range loads are dropped
      if (r.load_addr < ROM_SIZE) begin
        rom_image[r.load_addr]  = r.load_byte;
        rom_loaded[r.load_addr] = 1'b1;
      end
    end else if (r.sub_state == SUB_ACT) begin
      if (r.is_write_phase) begin
        if (active_op[CMD_DATA_BIT]) begin
          o.drive       = 1'b1;
          o.drive_value = rom_byte(p);
          p = p + 1;
          if (p >= ROM_SIZE) p = 0;      // wraps, also from beyond the ROM
        end else if (active_op[CMD_UNLOAD_BIT]) begin
          o.drive       = 1'b1;
          o.drive_value = 8'(p % 10);
          p = p / 10;
        end else if (active_op[CMD_HIGH_BIT]) begin
          o.drive       = 1'b1;
          o.drive_value = rom_byte(p) >> 4;
        end
        // no active bit: nothing driven, command kept
      end else begin
        active_op  = pending_op;
        pending_op = CMD_NONE;
        case (r.instr_word)
          INSTR_DATA:   pending_op = CMD_DATA;
          INSTR_SHIFT:  p = p / 10 + int'(r.ext_digit) * 1000;
          INSTR_UNLOAD: pending_op = CMD_UNLOAD;
          INSTR_HIGH:   pending_op = CMD_HIGH;
          default: ;
        endcase
      end
    end
    pc_model = PTR_W'(p);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders; fields the block ignores carry random bits
  // ---------------------------------------------------------------------------
  function automatic req_t rand_fill();
    return req_t'({$urandom, $urandom});
  endfunction

  function automatic req_t load_item(input logic [12:0] addr, input logic [7:0] data);
    req_t r;
    r           = rand_fill();
    r.action    = ACTION_LOAD;
    r.load_addr = addr;
    r.load_byte = data;
    return r;
  endfunction

  function automatic req_t bus_item(input logic phase, input logic [15:0] word,
                                    input logic [3:0] digit);
    req_t r;
    r                = rand_fill();
    r.action         = ACTION_BUS;
    r.sub_state      = SUB_ACT;
    r.is_write_phase = phase;
    r.instr_word     = word;
    r.ext_digit      = digit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request channel
  // ---------------------------------------------------------------------------
  // One handshake; the owed result is queued at the accepting edge.
  task automatic push_req(input req_t r);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    resp_due.push_back(bus_response(r));
  endtask

  // Sends a request; loads rom[pointer] first if an output phase would
  // otherwise read a byte never written.
  task automatic issue(input req_t r);
    if (r.action == ACTION_BUS && r.sub_state == SUB_ACT && r.is_write_phase &&
        reads_rom() && pc_model < ROM_SIZE && !rom_loaded[pc_model])
      push_req(load_item(13'(pc_model), 8'($urandom)));
    push_req(r);
  endtask

  task automatic instr(input logic [15:0] word, input logic [3:0] digit = 4'd0);
    issue(bus_item(1'b0, word, digit));
  endtask

  task automatic out_phase();
    issue(bus_item(1'b1, 16'($urandom), 4'($urandom)));
  endtask

  // Decode a word, then a second instruction phase moves it to the active slot
  task automatic arm(input logic [15:0] word);
    instr(word);
    instr(INSTR_NOP);
  endtask

  // Five digit shifts give pointer = v for v up to 15999
  task automatic set_pc(input int v);
    instr(INSTR_SHIFT, 4'd0);
    instr(INSTR_SHIFT, 4'(v % 10));
    instr(INSTR_SHIFT, 4'((v / 10) % 10));
    instr(INSTR_SHIFT, 4'((v / 100) % 10));
    instr(INSTR_SHIFT, 4'(v / 1000));
  endtask

  task automatic wait_drained();
    while (resp_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Loads at the ends of the ROM and beyond it, ignored sub-cycles,
  // and an output phase with nothing active straight after reset
  task automatic test_loads_and_idle_bus();
    req_t r;
    issue(load_item(13'd0, 8'h00));
    issue(load_item(13'(ROM_SIZE - 1), 8'hFF));
    issue(load_item(13'd222, 8'hA5));
    issue(load_item(13'h1FFF, 8'h5A));        // above the ROM: dropped
    issue(load_item(13'(ROM_SIZE), 8'h3C));   // first address past the end
    r = bus_item(1'b0, INSTR_DATA, 4'hF);
    r.sub_state = 4'd14;                      // not the acting sub-cycle
    issue(r);
    r = bus_item(1'b1, 16'hFFFF, 4'hF);
    r.sub_state = 4'd0;
    issue(r);
    out_phase();                              // no command active yet
  endtask

  // Data read from the reset pointer, repeated output phases, high nibble
  task automatic test_data_and_nibble();
    arm(INSTR_DATA);
    out_phase();                              // rom[222]
    out_phase();                              // same command again, rom[223]
    arm(INSTR_HIGH);
    out_phase();
    instr(16'hFFFF);                          // unknown word clears pending
    instr(INSTR_NOP);
    out_phase();                              // nothing driven
  endtask

  // Pointer unload, digit shifts with large digits, reads past the ROM end
  task automatic test_pointer_digits();
    arm(INSTR_UNLOAD);
    out_phase();
    out_phase();
    set_pc(ROM_SIZE - 1);
    arm(INSTR_DATA);
    out_phase();                              // last byte, pointer wraps to 0
    out_phase();                              // rom[0]
    instr(INSTR_SHIFT, 4'hF);
    instr(INSTR_SHIFT, 4'hF);                 // pointer well past the ROM
    arm(INSTR_HIGH);
    out_phase();                              // reads zero
    arm(INSTR_UNLOAD);
    out_phase();
    set_pc(15999);
    arm(INSTR_DATA);
    out_phase();                              // zero, then wrap to 0
  endtask

  // Mostly well-formed bus traffic with random content
  task automatic random_request();
    req_t r;
    int   pick;
    int   w;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r = load_item(13'($urandom), 8'($urandom));
    end else if (pick < 22) begin
      r = rand_fill();
      r.action    = ACTION_BUS;
      r.sub_state = 4'($urandom_range(0, 14));
    end else begin
      w = $urandom_range(0, 9);
      r = bus_item(1'($urandom), 16'($urandom),
                   ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4))
                                              : 4'($urandom));
      if (!r.is_write_phase) begin
        case (w)
          0, 1: r.instr_word = INSTR_DATA;
          2:    r.instr_word = INSTR_SHIFT;
          3, 4: r.instr_word = INSTR_UNLOAD;
          5, 6: r.instr_word = INSTR_HIGH;
          default: ;                          // random word, mostly unknown
        endcase
      end
    end
    issue(r);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RAND_REQS; i++) begin
      gaps_on = !(i >= 500 && i < 800);       // long stretch at full rate
      random_request();
    end
    gaps_on = 1'b1;
  endtask

  // Sender holds off until everything owed has come back, then bursts
  task automatic test_pause_and_resume();
    for (int i = 0; i < 30; i++) random_request();
    req_ch.valid <= 1'b0;
    wait_drained();
    for (int i = 0; i < 30; i++) random_request();
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver, monitor, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (resp_due.size() == 0) begin
        $error("unexpected result: drive %0d, drive_value %0h",
               res_ch.data.drive, res_ch.data.drive_value);
        mismatch_seen = 1'b1;
      end else begin
        want = resp_due.pop_front();
        if (res_ch.data.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, res_ch.data.drive);
          mismatch_seen = 1'b1;
        end
        if (res_ch.data.drive_value !== want.drive_value) begin
          $error("drive_value: expected %0h, got %0h",
                 want.drive_value, res_ch.data.drive_value);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > WAIT_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    gaps_on       = 1'b1;
    mismatch_seen = 1'b0;
    cycle_count   = 0;
    pc_model      = PTR_RESET;
    pending_op    = CMD_NONE;
    active_op     = CMD_NONE;
    foreach (rom_loaded[i]) rom_loaded[i] = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_loads_and_idle_bus();
    test_data_and_nibble();
    test_pointer_digits();
    test_random_traffic();
    test_pause_and_resume();

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);   // any stray result shows here

    if (mismatch_seen) begin
      $display("FAIL");
    end else begin
      $display("PASS");
    end
    $finish;
  end

endmodule
